FILE: rtl/pts_pkg.sv
// Package for the periodic timer scheduler.
// Holds sizes, codes, item types and the records passed along the cell chain.
// No dependencies.
package pts_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TGT_W      = 4;
  localparam int HANDLE_W   = 4;
  localparam int TIME_W     = 64;
  localparam int CMP_W      = (IDX_W > TGT_W) ? IDX_W : TGT_W;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_KILL = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_REFUSED = 3'd2,
    ST_KILLED  = 3'd3,
    ST_FIRED   = 3'd4,
    ST_IDLE    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    action_t           action;
    logic [TGT_W-1:0]  target_slot;
    logic [TIME_W-1:0] first_expiry;
    logic [TIME_W-1:0] repeat_period;
    logic [TIME_W-1:0] current_time;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
  } out_item_t;

  // Record handed from cell to cell as the scan wave moves down the row.
  typedef struct packed {
    logic              token;   // wave is at this point of the chain
    logic              hit;     // slot claimed (add) or best candidate found (tick)
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] expiry;
  } carry_t;

  // Item controls seen by every cell at once.
  typedef struct packed {
    action_t           action;
    logic              add_en;
    logic [TGT_W-1:0]  target;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] period;
    logic              fire_en;
    logic [IDX_W-1:0]  fire_idx;
  } bcast_t;

  function automatic logic [HANDLE_W-1:0] to_handle(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[HANDLE_W-1:0];
  endfunction

endpackage

FILE: rtl/pts_cell.sv
// One timer slot of the scheduler chain: valid bit, expiry and period.
// Registers the carry record toward the next cell. Depends on pts_pkg.
module pts_cell import pts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  bcast_t           bcast,
  input  carry_t           carry_in,
  output carry_t           carry_out
);

  logic              valid;
  logic [TIME_W-1:0] expiry;
  logic [TIME_W-1:0] period;
  carry_t            carry_next;
  logic              claim;
  logic              kill_me;
  logic              better;
  logic              fire_me;

  always_comb begin
    claim   = carry_in.token && bcast.action == ACT_ADD && bcast.add_en
              && !valid && !carry_in.hit;
    kill_me = carry_in.token && bcast.action == ACT_KILL
              && CMP_W'(cell_idx) == CMP_W'(bcast.target);
    better  = carry_in.token && bcast.action == ACT_TICK && valid
              && (!carry_in.hit || expiry < carry_in.expiry);
    fire_me = bcast.fire_en && bcast.fire_idx == cell_idx;

    carry_next = carry_in;
    if (claim || better) begin
      carry_next.hit    = 1'b1;
      carry_next.idx    = cell_idx;
      carry_next.expiry = expiry;
    end
  end

  always_ff @(posedge clk) begin
    carry_out.hit    <= carry_next.hit;
    carry_out.idx    <= carry_next.idx;
    carry_out.expiry <= carry_next.expiry;
    if (rst) begin
      valid           <= 1'b0;
      carry_out.token <= 1'b0;
    end else begin
      carry_out.token <= carry_next.token;
      if (claim) begin
        valid <= 1'b1;
      end else if (kill_me) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      expiry <= bcast.expiry;
      period <= bcast.period;
    end else if (fire_me) begin
      expiry <= expiry + period;
    end
  end

endmodule

FILE: rtl/pts_ctrl.sv
// Controller of the scheduler: handshakes, config register, wave launch,
// result decision and re-arm request. Depends on pts_pkg.
module pts_ctrl import pts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  output bcast_t    bcast,
  output carry_t    inject,
  input  carry_t    chain_end
);

  ctrl_state_t       state, state_next;
  in_item_t          item;
  logic              refused;
  logic              add_en;
  logic [TIME_W-1:0] clamp_exp;
  logic              fire_en;
  logic [IDX_W-1:0]  fire_idx;
  out_item_t         res, res_next;
  logic              fire_next;
  logic              accept;
  logic              load_out;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (chain_end.token) state_next = S_DONE;
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = state == S_IDLE;
    cfg_ready = 1'b1;
    accept    = in_valid && in_ready;
    load_out  = state == S_DONE && (!out_valid || out_ready);
  end

  // result decision at the chain end
  always_comb begin
    res_next  = '{status: ST_IDLE, handle: '0};
    fire_next = 1'b0;
    case (item.action)
      ACT_ADD: begin
        if (chain_end.hit) begin
          res_next = '{status: ST_ADDED, handle: to_handle(chain_end.idx)};
        end else if (!add_en) begin
          res_next.status = ST_REFUSED;
        end else begin
          res_next.status = ST_FULL;
        end
      end
      ACT_KILL: begin
        res_next = '{status: ST_KILLED, handle: item.target_slot};
      end
      ACT_TICK: begin
        if (chain_end.hit && chain_end.expiry <= item.current_time) begin
          res_next  = '{status: ST_FIRED, handle: to_handle(chain_end.idx)};
          fire_next = 1'b1;
        end
      end
      default: res_next = '{status: ST_IDLE, handle: '0};
    endcase
  end

  always_comb begin
    bcast.action   = item.action;
    bcast.add_en   = add_en;
    bcast.target   = item.target_slot;
    bcast.expiry   = clamp_exp;
    bcast.period   = item.repeat_period;
    bcast.fire_en  = fire_en;
    bcast.fire_idx = fire_idx;
  end

  always_ff @(posedge clk) begin
    inject.hit    <= 1'b0;
    inject.idx    <= '0;
    inject.expiry <= '0;
    if (rst) begin
      state        <= S_IDLE;
      refused      <= 1'b0;
      inject.token <= 1'b0;
      fire_en      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      inject.token <= accept;
      fire_en      <= state == S_SCAN && chain_end.token && fire_next;
      if (cfg_valid && cfg_ready) begin
        refused <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= in_data;
      add_en    <= !refused;
      clamp_exp <= (in_data.first_expiry < in_data.current_time) ?
                   in_data.current_time : in_data.first_expiry;
    end
    if (state == S_SCAN && chain_end.token) begin
      res      <= res_next;
      fire_idx <= chain_end.idx;
    end
    if (load_out) begin
      out_data <= res;
    end
  end

  a_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain_end.token |-> state == S_SCAN)
    else $error("chain end token outside scan");

  a_launch: assert property (@(posedge clk) disable iff (rst)
    accept |=> inject.token && state == S_SCAN)
    else $error("accepted item did not launch a wave");

  a_fire_done: assert property (@(posedge clk) disable iff (rst)
    fire_en |-> state == S_DONE)
    else $error("re-arm outside result state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DONE) |-> !in_ready)
    else $error("input ready while an item is in flight");

endmodule

FILE: rtl/periodic_timer_scheduler_top.sv
// Periodic timer scheduler, top level: a row of NUM_TIMERS timer cells and a controller.
// One item at a time: in_ready is high only in IDLE, so the next item waits while the scan
// wave runs through the cell row and until the result is loaded into the output register.
// An empty or draining output register lets the next item in; a stalled result waits in DONE.
// Reset (rst, synchronous) clears all slot valid bits, the refused flag and control; no clearing pass.
// Depends on pts_pkg, pts_cell, pts_ctrl.
module periodic_timer_scheduler_top import pts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  // Every item runs as one wave down the chain, one cell per cycle:
  //   add  - first free cell claims the slot (unless adds are refused) and marks the carry as hit
  //   kill - the addressed cell drops its valid bit
  //   tick - each valid cell replaces the carried best on a strictly earlier
  //          expiry, so ties stay with the lowest slot
  // At the chain end the controller decides the result; a firing tick sends a
  // one-cycle re-arm request that the chosen cell applies (expiry += period).
  bcast_t bcast;
  carry_t chain [NUM_TIMERS+1];

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .bcast     (bcast),
    .inject    (chain[0]),
    .chain_end (chain[NUM_TIMERS])
  );

  // Cell row; each cell registers the carry for its right neighbor.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    pts_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(i)),
      .bcast     (bcast),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1])
    );
  end

endmodule

FILE: dv/tb_periodic_timer_scheduler_top.sv
`timescale 1ns / 1ps
// Testbench for periodic_timer_scheduler_top: directed and random add/kill/tick/unused-code traffic.
// Depends on pts_pkg and the scheduler RTL; a class-based scoreboard predicts each result.
module tb_periodic_timer_scheduler_top;
  import pts_pkg::*;

  // Unused action code: the block must answer it with nothing-due.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Quiet time before a register write and at the end: one full scan plus margin.
  localparam int DRAIN_CYCLES = NUM_TIMERS + 4;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Shadow of the timer table. note_item() updates it in accept order and queues
  // the result the block owes; check_result() pops and compares.
  class timer_scoreboard;
    bit                armed[NUM_TIMERS];
    logic [TIME_W-1:0] expiry_at[NUM_TIMERS];
    logic [TIME_W-1:0] period_of[NUM_TIMERS];
    bit                adds_refused;
    out_item_t         owed[$];
    int                errors;

    function new();
      int i;
      for (i = 0; i < NUM_TIMERS; i++) begin
        armed[i]     = 1'b0;
        expiry_at[i] = '0;
        period_of[i] = '0;
      end
      adds_refused = 1'b0;
      errors       = 0;
    endfunction

    function void set_refused(bit v);
      adds_refused = v;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_item(in_item_t it);
      out_item_t res;
      int        i;
      int        best;
      res.status = ST_IDLE;
      res.handle = '0;
      best       = -1;
      case (it.action)
        ACT_ADD: begin
          if (adds_refused) begin
            res.status = ST_REFUSED;
          end else begin
            res.status = ST_FULL;
            for (i = 0; i < NUM_TIMERS && res.status == ST_FULL; i++) begin
              if (!armed[i]) begin
                armed[i]     = 1'b1;
                // clamp: a timer can't start in the past
                expiry_at[i] = (it.first_expiry < it.current_time) ? it.current_time
                                                                   : it.first_expiry;
                period_of[i] = it.repeat_period;
                res.status   = ST_ADDED;
                res.handle   = HANDLE_W'(i);
              end
            end
          end
        end
        ACT_KILL: begin
          if (int'(it.target_slot) < NUM_TIMERS) armed[it.target_slot] = 1'b0;
          res.status = ST_KILLED;
          res.handle = it.target_slot;
        end
        ACT_TICK: begin
          // strict less-than keeps the lowest slot on equal expiries
          for (i = 0; i < NUM_TIMERS; i++) begin
            if (armed[i] && (best < 0 || expiry_at[i] < expiry_at[best])) best = i;
          end
          if (best >= 0 && expiry_at[best] <= it.current_time) begin
            expiry_at[best] = expiry_at[best] + period_of[best];  // wraps mod 2^64
            res.status      = ST_FIRED;
            res.handle      = HANDLE_W'(best);
          end
        end
        default: ;
      endcase
      owed.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (owed.size() == 0) begin
        $error("unexpected result: status %0d handle %0d", got.status, got.handle);
        errors++;
        return;
      end
      exp_res = owed.pop_front();
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, got.status);
        errors++;
      end
      if (got.handle !== exp_res.handle) begin
        $error("handle: expected %0d, actual %0d", exp_res.handle, got.handle);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  timer_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Random traffic time base: ticks mostly move it forward in small steps, rarely set it at random.
  logic [TIME_W-1:0] clock_now = '0;

  periodic_timer_scheduler_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: values read right after the edge are the ones the block saw.
  // ready is redrawn every cycle so stalls land on every phase of the scan.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t make_item(action_t a, logic [TGT_W-1:0] tgt,
                                         logic [TIME_W-1:0] first,
                                         logic [TIME_W-1:0] per,
                                         logic [TIME_W-1:0] now);
    in_item_t it;
    it.action        = a;
    it.target_slot   = tgt;
    it.first_expiry  = first;
    it.repeat_period = per;
    it.current_time  = now;
    return it;
  endfunction

  // Mostly well-formed timer traffic near clock_now so timers actually fire;
  // full-width values now and then for clamping, wrap and bit coverage.
  // Ignored fields carry random noise.
  function automatic in_item_t random_timer_op();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    it   = make_item(ACT_KILL, 4'($urandom_range(15)), rand_time(), rand_time(), rand_time());
    if (pick < 36) begin
      it.action       = ACT_ADD;
      it.current_time = clock_now;
      case ($urandom_range(9))
        0:       ;                                                       // anything
        1:       it.first_expiry = clock_now - 64'($urandom_range(500)); // in the past
        default: it.first_expiry = clock_now + 64'($urandom_range(300));
      endcase
      if ($urandom_range(9) != 0) it.repeat_period = 64'($urandom_range(120));
    end else if (pick < 56) begin
      it.action = ACT_KILL;
    end else if (pick < 96) begin
      it.action = ACT_TICK;
      if ($urandom_range(49) == 0) clock_now = rand_time();
      else clock_now = clock_now + 64'($urandom_range(60));
      it.current_time = clock_now;
    end else begin
      it.action = action_t'(ACT_UNUSED);
    end
    return it;
  endfunction

  // valid is only dropped while idling, so back-to-back items keep it high
  task automatic push_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes only with the block idle and every result in.
  task automatic write_refused(bit v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_refused(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    int i;
    // empty table, kill of an idle slot
    push_item(make_item(ACT_TICK, 4'd0, '0, '0, '0));
    push_item(make_item(ACT_KILL, 4'd15, '0, '0, '0));
    // fill the table: zero period, max expiry/period, clamped start
    push_item(make_item(ACT_ADD, 4'd0, '0, '0, '0));
    push_item(make_item(ACT_ADD, 4'd0, TIME_MAX, TIME_MAX, '0));
    push_item(make_item(ACT_ADD, 4'd0, 64'd10, 64'd7, 64'd100));
    for (i = 3; i < NUM_TIMERS; i++) begin
      push_item(make_item(ACT_ADD, 4'd0, 64'(1000 + i), 64'(i), '0));
    end
    push_item(make_item(ACT_ADD, 4'd0, '0, '0, '0));            // table full
    // slot 0 has period 0, so it stays earliest and fires twice
    push_item(make_item(ACT_TICK, 4'd0, '0, '0, '0));
    push_item(make_item(ACT_TICK, 4'd0, '0, '0, 64'd100));
    push_item(make_item(ACT_KILL, 4'd0, '0, '0, '0));
    push_item(make_item(ACT_KILL, 4'd0, '0, '0, '0));           // already free
    push_item(make_item(ACT_TICK, 4'd0, '0, '0, 64'd50));       // earliest not yet due
    push_item(make_item(ACT_TICK, 4'd0, '0, '0, 64'd100));
    push_item(make_item(ACT_TICK, 4'd0, '0, '0, TIME_MAX));
    push_item(make_item(action_t'(ACT_UNUSED), 4'd5, TIME_MAX, TIME_MAX, TIME_MAX));
    write_refused(1'b1);
    push_item(make_item(ACT_ADD, 4'd0, '0, '0, '0));            // refused
    push_item(make_item(ACT_TICK, 4'd0, '0, '0, TIME_MAX));     // ticks still work
    write_refused(1'b0);
  endtask

  initial begin
    int phase;
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 52;
    run_directed();

    // Three idle patterns; each runs open traffic, then a stretch with adds refused.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 38; recv_idle_pct = 52; end
        1:       begin send_idle_pct = 52; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      write_refused(1'b0);
      for (n = 0; n < 400; n++) push_item(random_timer_op());
      write_refused(1'b1);
      for (n = 0; n < 133; n++) push_item(random_timer_op());
    end

    in_valid <= 1'b0;
    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
      $display("tb: failure");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
rtl/pts_pkg.sv
rtl/pts_cell.sv
rtl/pts_ctrl.sv
rtl/periodic_timer_scheduler_top.sv
dv/tb_periodic_timer_scheduler_top.sv
